/* rtl/core/idc_pkg.sv */
package idc_pkg;

   // Speaker codes, shared by output and input speakers.
   localparam logic [3:0] SPK_L    = 4'd0;
   localparam logic [3:0] SPK_R    = 4'd1;
   localparam logic [3:0] SPK_C    = 4'd2;
   localparam logic [3:0] SPK_LS   = 4'd3;
   localparam logic [3:0] SPK_RS   = 4'd4;
   localparam logic [3:0] SPK_LB   = 4'd5;
   localparam logic [3:0] SPK_RB   = 4'd6;
   localparam logic [3:0] SPK_TFL  = 4'd7;
   localparam logic [3:0] SPK_TFR  = 4'd8;
   localparam logic [3:0] SPK_TBL  = 4'd9;
   localparam logic [3:0] SPK_TBR  = 4'd10;
   localparam logic [3:0] SPK_LFE  = 4'd11;
   localparam logic [3:0] SPK_TSL  = 4'd12;
   localparam logic [3:0] SPK_TSR  = 4'd13;
   localparam logic [3:0] SPK_NONE = 4'd14;

   // Gain codes with a fixed meaning.
   localparam logic [2:0] GAIN_UNITY = 3'd0;
   localparam logic [2:0] GAIN_M3    = 3'd2;
   localparam logic [2:0] GAIN_ZERO  = 3'd7;

   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [30:0] Q30_P3  = 31'd1516700640;

   typedef struct packed {
      logic        decoding_core;
      logic        in_backs;
      logic [1:0]  in_tops;
      logic        lfe_present;
      logic [2:0]  out_layout;
      logic [2:0]  back_gain_code;
      logic [2:0]  top_pair_gain_code;
      logic [17:0] top_fold_gain_codes;
   } cfg_type;

   // Result of the speaker-pair decode: which gain, whether it carries +3 dB.
   typedef struct packed {
      logic [2:0] code;
      logic       p3;
      logic       silenced;
   } sel_type;

   function automatic logic [30:0] gain_q30(input logic [2:0] code);
      logic [30:0] g;
      case (code)
         3'd0:    g = 31'd1073741824;
         3'd1:    g = 31'd903441154;
         3'd2:    g = 31'd760150998;
         3'd3:    g = 31'd639587356;
         3'd4:    g = 31'd538145694;
         3'd5:    g = 31'd380977976;
         3'd6:    g = 31'd269711752;
         default: g = 31'd0;
      endcase
      return g;
   endfunction

endpackage

/* rtl/core/idc_decode.sv */
module idc_decode (
   input  idc_pkg::cfg_type cfg,
   input  logic [3:0]       out_speaker,
   input  logic [3:0]       in_speaker,
   output idc_pkg::sel_type sel
);
   import idc_pkg::*;

   localparam logic [2:0] LAYOUT_7X0 = 3'd3;
   localparam logic [2:0] LAYOUT_7X4 = 3'd5;
   localparam logic [2:0] LAYOUT_5X0 = 3'd0;
   localparam logic [2:0] LAYOUT_5X2 = 3'd1;
   localparam logic [2:0] LAYOUT_7X2 = 3'd4;

   localparam logic [2:0] TOPS_NONE = 3'd0;
   localparam logic [2:0] TOPS_PAIR = 3'd2;
   localparam logic [2:0] TOPS_QUAD = 3'd4;

   localparam logic [1:0] SRC_TOPS_NONE  = 2'd0;
   localparam logic [1:0] SRC_TOPS_FRONT = 2'd1;
   localparam logic [1:0] SRC_TOPS_BACK  = 2'd2;
   localparam logic [1:0] SRC_TOPS_FOUR  = 2'd3;

   function automatic logic is_pair(input logic [3:0] o, input logic [3:0] i,
                                    input logic [3:0] oa, input logic [3:0] ia);
      return (o == oa) && (i == ia);
   endfunction

   logic [3:0] o;
   logic [3:0] ie;
   logic [2:0] lay;
   logic [2:0] ot;
   logic [2:0] it;
   logic       ow7;
   logic       narrow_up;
   logic       planned;
   logic [2:0] f0, f1, f2, f3, f4, f5;
   logic [2:0] code;
   logic       p3;

   assign o  = out_speaker;
   assign f0 = cfg.top_fold_gain_codes[2:0];
   assign f1 = cfg.top_fold_gain_codes[5:3];
   assign f2 = cfg.top_fold_gain_codes[8:6];
   assign f3 = cfg.top_fold_gain_codes[11:9];
   assign f4 = cfg.top_fold_gain_codes[14:12];
   assign f5 = cfg.top_fold_gain_codes[17:15];

   always_comb begin
      lay = (cfg.out_layout > LAYOUT_7X4) ? LAYOUT_7X4 : cfg.out_layout;
      ow7 = (lay >= LAYOUT_7X0);
      case (lay) inside
         LAYOUT_5X0, LAYOUT_7X0: ot = TOPS_NONE;
         LAYOUT_5X2, LAYOUT_7X2: ot = TOPS_PAIR;
         default:                ot = TOPS_QUAD;
      endcase
      // Core decoding always renders to 5.X.0 or 5.X.2.
      if (cfg.decoding_core) begin
         ow7 = 1'b0;
         if (ot != TOPS_NONE) ot = TOPS_PAIR;
      end
      case (cfg.in_tops)
         SRC_TOPS_FOUR: it = TOPS_QUAD;
         SRC_TOPS_NONE: it = TOPS_NONE;
         default:       it = TOPS_PAIR;
      endcase
      narrow_up = ow7 && !cfg.in_backs;

      // Map the decoded input channel onto its matrix column.
      if (in_speaker > SPK_TSR) begin
         ie = SPK_NONE;
      end else if (cfg.decoding_core) begin
         ie = in_speaker;
      end else if ((in_speaker == SPK_LB || in_speaker == SPK_RB) && !cfg.in_backs) begin
         ie = SPK_NONE;
      end else if (in_speaker >= SPK_TFL && in_speaker <= SPK_TBR) begin
         case (cfg.in_tops)
            SRC_TOPS_FOUR:  ie = in_speaker;
            SRC_TOPS_FRONT: ie = (in_speaker == SPK_TFL) ? SPK_TSL :
                                 (in_speaker == SPK_TFR) ? SPK_TSR : SPK_NONE;
            SRC_TOPS_BACK:  ie = (in_speaker == SPK_TBL) ? SPK_TSL :
                                 (in_speaker == SPK_TBR) ? SPK_TSR : SPK_NONE;
            default:        ie = SPK_NONE;
         endcase
      end else begin
         ie = in_speaker;
      end

      code = GAIN_ZERO;
      p3   = 1'b0;
      if (is_pair(o, ie, SPK_L, SPK_L) || is_pair(o, ie, SPK_R, SPK_R) ||
          is_pair(o, ie, SPK_C, SPK_C)) begin
         code = GAIN_UNITY;
      end

      if (cfg.decoding_core) begin
         if (is_pair(o, ie, SPK_LS, SPK_LS) || is_pair(o, ie, SPK_RS, SPK_RS)) begin
            code = cfg.in_backs ? cfg.back_gain_code : GAIN_UNITY;
            p3   = 1'b1;
         end
         if (cfg.in_tops != SRC_TOPS_NONE) begin
            if (ot == TOPS_PAIR) begin
               if (is_pair(o, ie, SPK_TSL, SPK_TSL) || is_pair(o, ie, SPK_TSR, SPK_TSR)) begin
                  code = (cfg.in_tops == SRC_TOPS_FOUR) ? cfg.top_pair_gain_code : GAIN_UNITY;
                  p3   = 1'b1;
               end
            end else begin
               if (is_pair(o, ie, SPK_L, SPK_TSL) || is_pair(o, ie, SPK_R, SPK_TSR)) begin
                  code = f0;
                  p3   = 1'b1;
               end
               if (is_pair(o, ie, SPK_LS, SPK_TSL) || is_pair(o, ie, SPK_RS, SPK_TSR)) begin
                  code = f1;
                  p3   = 1'b1;
               end
            end
         end
      end else begin
         // Ear level: backs fold into the sides on a five-wide output.
         if (ow7) begin
            if (is_pair(o, ie, SPK_LS, SPK_LS) || is_pair(o, ie, SPK_RS, SPK_RS)) begin
               code = GAIN_UNITY;
            end
            if (cfg.in_backs &&
                (is_pair(o, ie, SPK_LB, SPK_LB) || is_pair(o, ie, SPK_RB, SPK_RB))) begin
               code = GAIN_UNITY;
            end
         end else if (cfg.in_backs) begin
            if (is_pair(o, ie, SPK_LS, SPK_LS) || is_pair(o, ie, SPK_LS, SPK_LB) ||
                is_pair(o, ie, SPK_RS, SPK_RS) || is_pair(o, ie, SPK_RS, SPK_RB)) begin
               code = (it == TOPS_NONE) ? GAIN_M3 : cfg.back_gain_code;
            end
         end else if (is_pair(o, ie, SPK_LS, SPK_LS) || is_pair(o, ie, SPK_RS, SPK_RS)) begin
            code = GAIN_UNITY;
         end

         if (it == TOPS_QUAD) begin
            if (ot == TOPS_QUAD) begin
               if (is_pair(o, ie, SPK_TFL, SPK_TFL) || is_pair(o, ie, SPK_TFR, SPK_TFR) ||
                   is_pair(o, ie, SPK_TBL, SPK_TBL) || is_pair(o, ie, SPK_TBR, SPK_TBR)) begin
                  code = GAIN_UNITY;
               end
            end else if (ot == TOPS_PAIR) begin
               if (is_pair(o, ie, SPK_TSL, SPK_TFL) || is_pair(o, ie, SPK_TSL, SPK_TBL) ||
                   is_pair(o, ie, SPK_TSR, SPK_TFR) || is_pair(o, ie, SPK_TSR, SPK_TBR)) begin
                  code = narrow_up ? GAIN_M3 : cfg.top_pair_gain_code;
               end
            end else if (narrow_up) begin
               if (is_pair(o, ie, SPK_LS, SPK_TFL) || is_pair(o, ie, SPK_RS, SPK_TFR) ||
                   is_pair(o, ie, SPK_LS, SPK_TBL) || is_pair(o, ie, SPK_RS, SPK_TBR)) begin
                  code = GAIN_M3;
               end
            end else begin
               if (is_pair(o, ie, SPK_L, SPK_TFL) || is_pair(o, ie, SPK_R, SPK_TFR))
                  code = f0;
               if (is_pair(o, ie, SPK_LS, SPK_TFL) || is_pair(o, ie, SPK_RS, SPK_TFR))
                  code = f1;
               if (is_pair(o, ie, SPK_L, SPK_TBL) || is_pair(o, ie, SPK_R, SPK_TBR))
                  code = f3;
               if (is_pair(o, ie, SPK_LS, SPK_TBL) || is_pair(o, ie, SPK_RS, SPK_TBR))
                  code = f4;
               if (ow7) begin
                  if (is_pair(o, ie, SPK_LB, SPK_TFL) || is_pair(o, ie, SPK_RB, SPK_TFR))
                     code = f2;
                  if (is_pair(o, ie, SPK_LB, SPK_TBL) || is_pair(o, ie, SPK_RB, SPK_TBR))
                     code = f5;
               end
            end
         end else if (it == TOPS_PAIR) begin
            if (ot == TOPS_QUAD) begin
               if (is_pair(o, ie, SPK_TFL, SPK_TSL) || is_pair(o, ie, SPK_TFR, SPK_TSR) ||
                   is_pair(o, ie, SPK_TBL, SPK_TSL) || is_pair(o, ie, SPK_TBR, SPK_TSR)) begin
                  code = GAIN_M3;
               end
            end else if (ot == TOPS_PAIR) begin
               if (is_pair(o, ie, SPK_TSL, SPK_TSL) || is_pair(o, ie, SPK_TSR, SPK_TSR))
                  code = GAIN_UNITY;
            end else if (narrow_up) begin
               if (is_pair(o, ie, SPK_LS, SPK_TSL) || is_pair(o, ie, SPK_RS, SPK_TSR))
                  code = GAIN_M3;
            end else begin
               if (is_pair(o, ie, SPK_L, SPK_TSL) || is_pair(o, ie, SPK_R, SPK_TSR))
                  code = f0;
               if (is_pair(o, ie, SPK_LS, SPK_TSL) || is_pair(o, ie, SPK_RS, SPK_TSR))
                  code = f1;
               if (ow7 &&
                   (is_pair(o, ie, SPK_LB, SPK_TSL) || is_pair(o, ie, SPK_RB, SPK_TSR)))
                  code = f2;
            end
         end
      end

      if (cfg.lfe_present && is_pair(o, ie, SPK_LFE, SPK_LFE)) begin
         code = GAIN_UNITY;
         p3   = 1'b0;
      end

      // Is the output speaker part of the rendered layout?
      if (o <= SPK_RS)
         planned = 1'b1;
      else if (o == SPK_LFE)
         planned = cfg.lfe_present;
      else if (o == SPK_LB || o == SPK_RB)
         planned = ow7;
      else if (o >= SPK_TFL && o <= SPK_TBR)
         planned = (ot == TOPS_QUAD);
      else if (o == SPK_TSL || o == SPK_TSR)
         planned = (ot == TOPS_PAIR);
      else
         planned = 1'b0;

      if (ie == SPK_NONE || !planned) begin
         code = GAIN_ZERO;
         p3   = 1'b0;
      end

      sel.code     = code;
      sel.p3       = p3;
      sel.silenced = (ie == SPK_NONE);
   end

endmodule

/* rtl/core/immersive_downmix_coefficient.sv */
// Channel  Direction  Payload
// req      in         tdata[3:0] out_speaker, tdata[7:4] in_speaker
// rsp      out        tdata[14:0] coefficient (tdata[15] zero), tuser in_silenced
// csr      in         csr_we, csr_index, csr_wdata (write only)
//
// Four register stages: pair decode, gain lookup, 31x31 multiply, round and
// saturate into the output register. One beat enters per cycle unless the pipe
// is full behind a stalled output. Each stage stalls only when it is full and the
// stage after it is blocked, so empty slots fill up while a result waits.
// Synchronous reset empties the pipe and loads the register defaults.
module immersive_downmix_coefficient #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] out_speaker, [7:4] in_speaker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] coefficient, [15] zero
   output logic        rsp_tuser,   // [0] in_silenced
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_wdata
);
   import idc_pkg::*;

   localparam logic [2:0] CSR_DECODING_CORE  = 3'd0;
   localparam logic [2:0] CSR_IN_BACKS       = 3'd1;
   localparam logic [2:0] CSR_IN_TOPS        = 3'd2;
   localparam logic [2:0] CSR_LFE_PRESENT    = 3'd3;
   localparam logic [2:0] CSR_OUT_LAYOUT     = 3'd4;
   localparam logic [2:0] CSR_BACK_GAIN      = 3'd5;
   localparam logic [2:0] CSR_TOP_PAIR_GAIN  = 3'd6;
   localparam logic [2:0] CSR_TOP_FOLD_GAINS = 3'd7;

   localparam int          SH         = 60 - COEF_FRAC_BITS;
   localparam logic [61:0] ROUND_HALF = 62'd1 << (SH - 1);
   localparam logic [61:0] COEF_MAX   = 62'd32767;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decoding_core       <= 1'b0;
         cfg_ff.in_backs            <= 1'b0;
         cfg_ff.in_tops             <= 2'd0;
         cfg_ff.lfe_present         <= 1'b0;
         cfg_ff.out_layout          <= 3'd0;
         cfg_ff.back_gain_code      <= 3'd2;
         cfg_ff.top_pair_gain_code  <= 3'd2;
         cfg_ff.top_fold_gain_codes <= 18'd241623;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECODING_CORE:  cfg_ff.decoding_core       <= csr_wdata[0];
            CSR_IN_BACKS:       cfg_ff.in_backs            <= csr_wdata[0];
            CSR_IN_TOPS:        cfg_ff.in_tops             <= csr_wdata[1:0];
            CSR_LFE_PRESENT:    cfg_ff.lfe_present         <= csr_wdata[0];
            CSR_OUT_LAYOUT:     cfg_ff.out_layout          <= csr_wdata[2:0];
            CSR_BACK_GAIN:      cfg_ff.back_gain_code      <= csr_wdata[2:0];
            CSR_TOP_PAIR_GAIN:  cfg_ff.top_pair_gain_code  <= csr_wdata[2:0];
            CSR_TOP_FOLD_GAINS: cfg_ff.top_fold_gain_codes <= csr_wdata;
         endcase
      end
   end

   sel_type sel_in, sel_ff;

   idc_decode u_decode (
      .cfg         (cfg_ff),
      .out_speaker (req_tdata[3:0]),
      .in_speaker  (req_tdata[7:4]),
      .sel         (sel_in)
   );

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   logic [30:0] gain_in, gain_ff;
   logic [30:0] factor_in, factor_ff;
   logic        sil2_ff, sil3_ff, sil4_ff;
   logic [61:0] product_in, product_ff;
   logic [61:0] rounded;
   logic [61:0] scaled;
   logic [14:0] coef_in, coef_ff;

   assign gain_in    = gain_q30(sel_ff.code);
   assign factor_in  = sel_ff.p3 ? Q30_P3 : Q30_ONE;
   assign product_in = 62'(gain_ff) * 62'(factor_ff);
   assign rounded    = product_ff + ROUND_HALF;
   assign scaled     = rounded >> SH;
   assign coef_in    = (scaled > COEF_MAX) ? COEF_MAX[14:0] : scaled[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) sel_ff <= sel_in;
      if (rdy2) begin
         gain_ff   <= gain_in;
         factor_ff <= factor_in;
         sil2_ff   <= sel_ff.silenced;
      end
      if (rdy3) begin
         product_ff <= product_in;
         sil3_ff    <= sil2_ff;
      end
      if (rdy4) begin
         coef_ff <= coef_in;
         sil4_ff <= sil3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {1'b0, coef_ff};
   assign rsp_tuser  = sil4_ff;

   // A silenced input never contributes gain.
   a_silenced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[14:0] == 15'd0)
      else $error("silenced beat carries a nonzero coefficient");

   // A full pipe behind a stalled output must refuse new beats.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready |-> !req_tready)
      else $error("beat accepted into a full, stalled pipeline");

   // A beat in the multiply stage moves into the output register when it can.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      v3_ff && rdy4 |=> rsp_tvalid)
      else $error("beat lost between multiply and output stage");

   // An empty decode stage always takes a beat.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("empty pipeline refuses input");

endmodule
